// ===== hdl/ber_tlv_stream_parser_core_macros.svh =====
// Assertion macros for the BER-TLV stream parser.
// Used by the parser step logic and the top level; no other dependencies.
// Define ASSERT_OFF to compile the checks away.
`ifndef BER_TLV_STREAM_PARSER_CORE_MACROS_SVH
`define BER_TLV_STREAM_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BTLV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BTLV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define BTLV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BTLV_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV stream parser.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package btlv_pkg;

  localparam int BYTE_W = 8;
  localparam int TAG_W  = 16;
  localparam int LEN_W  = 16;

  localparam logic [BYTE_W-1:0] STOP_LO    = 8'h00;
  localparam logic [BYTE_W-1:0] STOP_HI    = 8'hFF;
  localparam logic [4:0]        TAG_MORE   = 5'h1F;
  localparam logic [6:0]        LEN_ONE    = 7'h01;
  localparam logic [6:0]        LEN_TWO    = 7'h02;

  typedef enum logic [2:0] {
    PH_TAG1  = 3'd0,
    PH_TAG2  = 3'd1,
    PH_LEN   = 3'd2,
    PH_L1OF1 = 3'd3,
    PH_L1OF2 = 3'd4,
    PH_L2OF2 = 3'd5,
    PH_VALUE = 3'd6,
    PH_STOP  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER   = 3'd0,
    K_VALUE    = 3'd1,
    K_STOPBYTE = 3'd2,
    K_BADLEN   = 3'd3,
    K_NOTHING  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   elem_length;
    logic [BYTE_W-1:0]  value_byte;
    logic               truncated;
    logic               buffer_end;
  } result_t;

  // One step's outcome, handed from the step logic to the output stage.
  typedef struct packed {
    logic    emit;
    result_t res;
  } step_out_t;

endpackage

// ===== hdl/btlv_stream_if.sv =====
// Valid/ready channel interfaces for the BER-TLV stream parser.
// Depends on btlv_pkg for field widths and the result kind type.
`timescale 1ns / 1ps

interface btlv_in_if;
  logic                      valid;
  logic                      ready;
  logic [btlv_pkg::BYTE_W-1:0] data_byte;
  logic                      last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface btlv_out_if;
  logic                        valid;
  logic                        ready;
  btlv_pkg::kind_t             kind;
  logic [btlv_pkg::TAG_W-1:0]  tag;
  logic [btlv_pkg::LEN_W-1:0]  elem_length;
  logic [btlv_pkg::BYTE_W-1:0] value_byte;
  logic                        truncated;
  logic                        buffer_end;

  modport source (output valid, output kind, output tag, output elem_length,
                  output value_byte, output truncated, output buffer_end,
                  input ready);
  modport sink   (input valid, input kind, input tag, input elem_length,
                  input value_byte, input truncated, input buffer_end,
                  output ready);
endinterface

// ===== hdl/btlv_step.sv =====
// Phase machine and element holds of the BER-TLV stream parser.
// Depends on btlv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ber_tlv_stream_parser_core_macros.svh"

module btlv_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [btlv_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last,
  output btlv_pkg::step_out_t         step_out
);

  btlv_pkg::phase_t              phase_r, phase_nxt, phase_step;
  logic [btlv_pkg::TAG_W-1:0]    tag_hold_r, tag_hold_nxt;
  logic [btlv_pkg::LEN_W-1:0]    length_hold_r, length_hold_nxt;
  logic [btlv_pkg::LEN_W-1:0]    value_left_r, value_left_nxt;

  logic                          is_stop;
  logic [btlv_pkg::LEN_W-1:0]    len_w;
  logic                          len_zero;

  assign is_stop  = (data_byte == btlv_pkg::STOP_LO) || (data_byte == btlv_pkg::STOP_HI);
  // Completed length for whichever length form this byte closes.
  assign len_w    = (phase_r == btlv_pkg::PH_L2OF2) ?
                    {length_hold_r[btlv_pkg::BYTE_W-1:0], data_byte} :
                    {{(btlv_pkg::LEN_W-btlv_pkg::BYTE_W){1'b0}}, data_byte};
  assign len_zero = (len_w == '0);

  // Next phase
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      btlv_pkg::PH_TAG1: begin
        if (is_stop) begin
          phase_step = btlv_pkg::PH_STOP;
        end else if (data_byte[4:0] == btlv_pkg::TAG_MORE) begin
          phase_step = btlv_pkg::PH_TAG2;
        end else begin
          phase_step = btlv_pkg::PH_LEN;
        end
      end
      btlv_pkg::PH_TAG2: phase_step = btlv_pkg::PH_LEN;
      btlv_pkg::PH_LEN: begin
        if (data_byte[7]) begin
          if (data_byte[6:0] == btlv_pkg::LEN_ONE) begin
            phase_step = btlv_pkg::PH_L1OF1;
          end else if (data_byte[6:0] == btlv_pkg::LEN_TWO) begin
            phase_step = btlv_pkg::PH_L1OF2;
          end else begin
            phase_step = btlv_pkg::PH_STOP;
          end
        end else begin
          phase_step = len_zero ? btlv_pkg::PH_TAG1 : btlv_pkg::PH_VALUE;
        end
      end
      btlv_pkg::PH_L1OF1: phase_step = len_zero ? btlv_pkg::PH_TAG1 : btlv_pkg::PH_VALUE;
      btlv_pkg::PH_L1OF2: phase_step = btlv_pkg::PH_L2OF2;
      btlv_pkg::PH_L2OF2: phase_step = len_zero ? btlv_pkg::PH_TAG1 : btlv_pkg::PH_VALUE;
      btlv_pkg::PH_VALUE: begin
        phase_step = (value_left_r == btlv_pkg::LEN_W'(1)) ? btlv_pkg::PH_TAG1
                                                           : btlv_pkg::PH_VALUE;
      end
      btlv_pkg::PH_STOP: phase_step = btlv_pkg::PH_STOP;
    endcase

    phase_nxt = phase_r;
    if (step_en) begin
      phase_nxt = last ? btlv_pkg::PH_TAG1 : phase_step;
    end
  end

  // Holds and result
  always_comb begin
    logic complete;
    complete        = 1'b0;
    tag_hold_nxt    = tag_hold_r;
    length_hold_nxt = length_hold_r;
    value_left_nxt  = value_left_r;
    step_out        = '0;
    step_out.res.kind = btlv_pkg::K_NOTHING;

    unique case (phase_r)
      btlv_pkg::PH_TAG1: begin
        if (is_stop) begin
          step_out.emit     = 1'b1;
          step_out.res.kind = btlv_pkg::K_STOPBYTE;
        end else begin
          tag_hold_nxt    = {{(btlv_pkg::TAG_W-btlv_pkg::BYTE_W){1'b0}}, data_byte};
          length_hold_nxt = '0;
        end
      end
      btlv_pkg::PH_TAG2: begin
        tag_hold_nxt = {tag_hold_r[btlv_pkg::BYTE_W-1:0], data_byte};
      end
      btlv_pkg::PH_LEN: begin
        if (data_byte[7]) begin
          if ((data_byte[6:0] != btlv_pkg::LEN_ONE) && (data_byte[6:0] != btlv_pkg::LEN_TWO)) begin
            step_out.emit     = 1'b1;
            step_out.res.kind = btlv_pkg::K_BADLEN;
            step_out.res.tag  = tag_hold_r;
          end
        end else begin
          complete = 1'b1;
        end
      end
      btlv_pkg::PH_L1OF1: complete = 1'b1;
      btlv_pkg::PH_L1OF2: begin
        length_hold_nxt = {{(btlv_pkg::LEN_W-btlv_pkg::BYTE_W){1'b0}}, data_byte};
      end
      btlv_pkg::PH_L2OF2: complete = 1'b1;
      btlv_pkg::PH_VALUE: begin
        step_out.emit             = 1'b1;
        step_out.res.kind         = btlv_pkg::K_VALUE;
        step_out.res.tag          = tag_hold_r;
        step_out.res.elem_length  = length_hold_r;
        step_out.res.value_byte   = data_byte;
        value_left_nxt            = value_left_r - btlv_pkg::LEN_W'(1);
      end
      btlv_pkg::PH_STOP: ;
    endcase

    if (complete) begin
      length_hold_nxt          = len_w;
      value_left_nxt           = len_w;
      step_out.emit            = 1'b1;
      step_out.res.kind        = btlv_pkg::K_HEADER;
      step_out.res.tag         = tag_hold_r;
      step_out.res.elem_length = len_w;
    end

    // Buffer end: always report, flag an unfinished element, start clean.
    if (last) begin
      step_out.emit           = 1'b1;
      step_out.res.buffer_end = 1'b1;
      step_out.res.truncated  = (phase_step != btlv_pkg::PH_TAG1) &&
                                (phase_step != btlv_pkg::PH_STOP);
      tag_hold_nxt    = '0;
      length_hold_nxt = '0;
      value_left_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= btlv_pkg::PH_TAG1;
      tag_hold_r    <= '0;
      length_hold_r <= '0;
      value_left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (step_en) begin
        tag_hold_r    <= tag_hold_nxt;
        length_hold_r <= length_hold_nxt;
        value_left_r  <= value_left_nxt;
      end
    end
  end

  `BTLV_ASSERT_NXT(a_last_restarts, clk, rst_n, step_en && last,
                   (phase_r == btlv_pkg::PH_TAG1) && (value_left_r == '0))
  `BTLV_ASSERT_IMP(a_value_has_count, clk, rst_n, phase_r == btlv_pkg::PH_VALUE,
                   value_left_r != '0)

endmodule

// ===== hdl/btlv_out_reg.sv =====
// Output register stage of the BER-TLV stream parser: holds one result beat.
// Depends on btlv_pkg and the btlv_out_if interface.
`timescale 1ns / 1ps

module btlv_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_en,
  input  btlv_pkg::step_out_t step_out,
  output logic                can_load,
  btlv_out_if.source          out_bus
);

  logic              valid_r, valid_nxt;
  btlv_pkg::result_t res_r;

  // Slot frees when empty or when the held beat leaves this cycle.
  assign can_load = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load_en && step_out.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_en && step_out.emit) begin
      res_r <= step_out.res;
    end
  end

  assign out_bus.valid       = valid_r;
  assign out_bus.kind        = res_r.kind;
  assign out_bus.tag         = res_r.tag;
  assign out_bus.elem_length = res_r.elem_length;
  assign out_bus.value_byte  = res_r.value_byte;
  assign out_bus.truncated   = res_r.truncated;
  assign out_bus.buffer_end  = res_r.buffer_end;

endmodule

// ===== hdl/ber_tlv_stream_parser_core.sv =====
// Top level of the BER-TLV stream parser core.
// Depends on btlv_pkg, btlv_stream_if, btlv_step, btlv_out_reg and the macro header.
`timescale 1ns / 1ps
`include "ber_tlv_stream_parser_core_macros.svh"

// Usage
//   in_bus  : one beat per buffer byte (data_byte, last marks the final byte).
//   out_bus : at most one result beat per input beat: element headers, value
//             bytes, stop and bad-length reports, and always a beat for the
//             byte marked last (buffer_end set, truncated if the buffer ended
//             inside a header or value).
//   Output  : a result is registered and shows on out_bus the cycle after its beat.
//   Throughput: one byte per cycle while out_bus is not stalled; the phase machine
//             advances once per accepted beat; one output register is the only stage.
//   Header bytes that finish nothing, and bytes after a stop, give no beat.
//   Reset   : rst_n low (synchronous) returns the walk to the first tag byte,
//             clears the holds and empties the output register.
//   Stall   : while out_bus.ready is low and a result is held, in_bus.ready
//             drops; the held beat stays put until taken. A held beat that
//             leaves in the same cycle frees the slot, so no bubble appears.
//   The byte marked last returns the walk to its reset state, so the next
//   beat starts a new buffer.

module ber_tlv_stream_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  btlv_in_if.sink    in_bus,
  btlv_out_if.source out_bus
);

  btlv_pkg::step_out_t step_out;
  logic                can_load;
  logic                in_acc;

  // Accept a byte whenever the output slot can take its result.
  assign in_bus.ready = can_load;
  assign in_acc       = in_bus.valid && can_load;

  btlv_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .data_byte (in_bus.data_byte),
    .last      (in_bus.last),
    .step_out  (step_out)
  );

  btlv_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_en  (in_acc),
    .step_out (step_out),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

  `BTLV_ASSERT_NXT(a_last_beat_out, clk, rst_n, in_acc && in_bus.last,
                   out_bus.valid && out_bus.buffer_end)
  `BTLV_ASSERT_IMP(a_value_byte_clear, clk, rst_n,
                   out_bus.valid && (out_bus.kind != btlv_pkg::K_VALUE),
                   out_bus.value_byte == '0)

endmodule

// ===== tb/tb_ber_tlv_stream_parser_core.sv =====
// Testbench for ber_tlv_stream_parser_core: directed and random TLV buffers.
// Checks each result beat against an in-bench TLV walk model.
// Depends on btlv_pkg, btlv_stream_if and the parser RTL.
`timescale 1ns / 1ps

module tb_ber_tlv_stream_parser_core;

  typedef logic [7:0] byte_q_t[$];

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 600;

  logic clk;
  logic rst_n;

  btlv_in_if  in_bus ();
  btlv_out_if out_bus ();

  ber_tlv_stream_parser_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Walk state of the TLV model
  btlv_pkg::phase_t walk_ph;
  logic [15:0]      walk_tag;
  logic [15:0]      walk_len;
  logic [15:0]      walk_left;

  btlv_pkg::result_t tlv_results_due[$];
  int                mismatches;
  int                live_items;
  int                src_burst;
  int                sink_burst;
  int                idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_walk();
    walk_ph   = btlv_pkg::PH_TAG1;
    walk_tag  = '0;
    walk_len  = '0;
    walk_left = '0;
  endfunction

  // Advance the TLV walk by one byte; return 1 when the byte yields a result.
  function automatic logic walk_byte(input logic [7:0] b, input logic lst,
                                     output btlv_pkg::result_t r);
    logic        emit;
    logic        complete;
    logic [15:0] len;
    r = '0;
    r.kind = btlv_pkg::K_NOTHING;
    emit = 1'b0;
    complete = 1'b0;
    len = '0;
    case (walk_ph)
      btlv_pkg::PH_TAG1: begin
        if (b == btlv_pkg::STOP_LO || b == btlv_pkg::STOP_HI) begin
          r.kind = btlv_pkg::K_STOPBYTE;
          emit = 1'b1;
          walk_ph = btlv_pkg::PH_STOP;
        end else begin
          walk_tag = {8'h00, b};
          walk_len = '0;
          if (b[4:0] == btlv_pkg::TAG_MORE) walk_ph = btlv_pkg::PH_TAG2;
          else walk_ph = btlv_pkg::PH_LEN;
        end
      end
      btlv_pkg::PH_TAG2: begin
        walk_tag = {walk_tag[7:0], b};
        walk_ph = btlv_pkg::PH_LEN;
      end
      btlv_pkg::PH_LEN: begin
        if (b[7]) begin
          if (b[6:0] == btlv_pkg::LEN_ONE) begin
            walk_ph = btlv_pkg::PH_L1OF1;
          end else if (b[6:0] == btlv_pkg::LEN_TWO) begin
            walk_ph = btlv_pkg::PH_L1OF2;
          end else begin
            r.kind = btlv_pkg::K_BADLEN;
            r.tag = walk_tag;
            emit = 1'b1;
            walk_ph = btlv_pkg::PH_STOP;
          end
        end else begin
          len = {8'h00, b};
          complete = 1'b1;
        end
      end
      btlv_pkg::PH_L1OF1: begin
        len = {8'h00, b};
        complete = 1'b1;
      end
      btlv_pkg::PH_L1OF2: begin
        walk_len = {8'h00, b};
        walk_ph = btlv_pkg::PH_L2OF2;
      end
      btlv_pkg::PH_L2OF2: begin
        len = {walk_len[7:0], b};
        complete = 1'b1;
      end
      btlv_pkg::PH_VALUE: begin
        r.kind = btlv_pkg::K_VALUE;
        r.tag = walk_tag;
        r.elem_length = walk_len;
        r.value_byte = b;
        emit = 1'b1;
        walk_left = walk_left - 16'd1;
        if (walk_left == 16'd0) walk_ph = btlv_pkg::PH_TAG1;
      end
      default: ;
    endcase
    if (complete) begin
      walk_len = len;
      walk_left = len;
      r.kind = btlv_pkg::K_HEADER;
      r.tag = walk_tag;
      r.elem_length = len;
      emit = 1'b1;
      if (len != 16'd0) walk_ph = btlv_pkg::PH_VALUE;
      else walk_ph = btlv_pkg::PH_TAG1;
    end
    if (lst) begin
      r.truncated = (walk_ph != btlv_pkg::PH_TAG1 && walk_ph != btlv_pkg::PH_STOP);
      r.buffer_end = 1'b1;
      emit = 1'b1;
      clear_walk();
    end
    return emit;
  endfunction

  // Idle cycles before the next beat: mostly random, sometimes a run of none
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int                gap;
    btlv_pkg::result_t r;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last      <= lst;
    do @(posedge clk); while (!in_bus.ready);
    // Bytes after a stop only get ignored; don't count them as real stimulus
    if (walk_ph != btlv_pkg::PH_STOP) live_items++;
    if (walk_byte(b, lst, r)) tlv_results_due.push_back(r);
  endtask

  task automatic send_buffer(input byte_q_t bytes);
    for (int i = 0; i < bytes.size(); i++) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    btlv_pkg::result_t want;
    if (tlv_results_due.size() == 0) begin
      $error("result beat with no result pending: kind %0d tag 0x%0h",
             out_bus.kind, out_bus.tag);
      mismatches++;
    end else begin
      want = tlv_results_due.pop_front();
      check_field("kind", {13'd0, want.kind}, {13'd0, out_bus.kind});
      check_field("tag", want.tag, out_bus.tag);
      check_field("elem_length", want.elem_length, out_bus.elem_length);
      check_field("value_byte", {8'd0, want.value_byte}, {8'd0, out_bus.value_byte});
      check_field("truncated", {15'd0, want.truncated}, {15'd0, out_bus.truncated});
      check_field("buffer_end", {15'd0, want.buffer_end}, {15'd0, out_bus.buffer_end});
    end
  endtask

  // Empty value, one-byte tag and a complete value ending the buffer
  task automatic test_short_form();
    send_buffer('{8'h01, 8'h00, 8'h5A, 8'h01, 8'hAA});
  endtask

  // Two-byte tags, 0x81 and 0x82 lengths, extreme length, end inside value
  task automatic test_long_form();
    send_buffer('{8'h9F, 8'h01, 8'h81, 8'h00,
                  8'hDF, 8'h7F, 8'h82, 8'hFF, 8'hFF, 8'hC3});
    send_buffer('{8'h41, 8'h7F, 8'h80});
  endtask

  // Stop bytes at tag position, trailing byte ignored
  task automatic test_stop_bytes();
    send_buffer('{8'h00, 8'h12});
    send_buffer('{8'hFF});
  endtask

  task automatic test_bad_length();
    send_buffer('{8'h20, 8'h83});
  endtask

  // Buffer ends between the two bytes of a long length
  task automatic test_truncation();
    send_buffer('{8'h30, 8'h82, 8'h01});
  endtask

  // Mostly well-formed buffers with random content, some noise and cut-offs
  function automatic byte_q_t build_buffer();
    byte_q_t     q;
    int          nelem;
    int          form;
    int          nv;
    logic [7:0]  t;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] len;
    logic        done;
    done = 1'b0;
    if ($urandom_range(0, 99) < 8) begin
      nv = $urandom_range(1, 12);
      repeat (nv) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    nelem = $urandom_range(1, 4);
    for (int e = 0; e < nelem && !done; e++) begin
      if ($urandom_range(0, 99) < 4) begin
        q.push_back($urandom_range(0, 1) ? btlv_pkg::STOP_HI : btlv_pkg::STOP_LO);
        repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
        done = 1'b1;
      end else begin
        t = 8'($urandom_range(1, 254));
        if ($urandom_range(0, 3) == 0) t[4:0] = btlv_pkg::TAG_MORE;
        if (t == btlv_pkg::STOP_HI) t = 8'hDF;
        q.push_back(t);
        if (t[4:0] == btlv_pkg::TAG_MORE) q.push_back(8'($urandom_range(0, 255)));
        form = $urandom_range(0, 99);
        if (form < 55) begin
          len = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 6));
          q.push_back(len[7:0]);
        end else if (form < 75) begin
          len = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 8));
          q.push_back(8'h81);
          q.push_back(len[7:0]);
        end else if (form < 92) begin
          hi = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
          lo = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, 8));
          len = {hi, lo};
          q.push_back(8'h82);
          q.push_back(hi);
          q.push_back(lo);
        end else begin
          // Long form with a byte count other than one or two
          t = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(3, 127));
          q.push_back(8'h80 | t);
          repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
          done = 1'b1;
          len = '0;
        end
        if (!done) begin
          nv = (len > 16) ? $urandom_range(0, 16) : int'(len);
          repeat (nv) q.push_back(8'($urandom_range(0, 255)));
          if (nv < len) done = 1'b1;
        end
      end
    end
    // Sometimes cut the buffer short to land inside a header or value
    if ($urandom_range(0, 99) < 15 && q.size() > 1) begin
      nv = $urandom_range(1, q.size() - 1);
      while (q.size() > nv) void'(q.pop_back());
    end
    return q;
  endfunction

  task automatic test_random_buffers();
    int start;
    start = live_items;
    while (live_items - start < RANDOM_ITEMS) send_buffer(build_buffer());
  endtask

  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap(sink_burst);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      check_result();
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_ber_tlv_stream_parser_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches = 0;
    live_items = 0;
    src_burst = 0;
    sink_burst = 0;
    clear_walk();
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_short_form();
    test_long_form();
    test_stop_bytes();
    test_bad_length();
    test_truncation();
    test_random_buffers();

    in_bus.valid <= 1'b0;
    while (tlv_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_ber_tlv_stream_parser_core OK");
    end else begin
      $display("tb_ber_tlv_stream_parser_core NOT OK");
    end
    $finish;
  end

endmodule
